/* hw/rtl/hsv2rgb_pkg.sv */
// HSV to RGB converter: shared types and fixed-point constants.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hsv2rgb_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  // Field widths
  localparam int HUE_W  = 16;               // input hue word
  localparam int CH_W   = FRAC_BITS + 1;    // Q1.FRAC_BITS channel
  localparam int H_W    = 15;               // hue after reduction, below TURN
  localparam int POS_W  = 12;               // position within one sector
  localparam int PROD_W = 2 * FRAC_BITS + 1; // V*S product
  localparam int CR_W   = CH_W + POS_W - 1;  // C*ramp, never above ONE*SEG

  // Angle constants in hue units
  localparam int SEG_I  = 60 << HUE_FRAC_BITS;
  localparam int TURN_I = 6 * SEG_I;

  // SEG = SEG_ODD << SEG_SHIFT; the odd factor is divided out by reciprocal
  localparam int SEG_SHIFT   = HUE_FRAC_BITS + 2;
  localparam int SEG_ODD     = SEG_I >> SEG_SHIFT;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_I     = ((1 << RECIP_SHIFT) / SEG_ODD) + 1;
  localparam int RECIP_W     = 16;
  localparam int T_W         = CR_W + 1 - SEG_SHIFT;
  localparam int Q_W         = T_W + RECIP_W;

  localparam logic [CH_W-1:0]    ONE       = CH_W'(1 << FRAC_BITS);
  localparam logic [PROD_W-1:0]  HALF_ONE  = PROD_W'(1 << (FRAC_BITS - 1));
  localparam logic [HUE_W-1:0]   TURN      = HUE_W'(TURN_I);
  localparam logic [HUE_W-1:0]   TURN2     = HUE_W'(2 * TURN_I);
  localparam logic [POS_W-1:0]   SEG       = POS_W'(SEG_I);
  localparam logic [CR_W:0]      HALF_SEG  = (CR_W + 1)'(SEG_I / 2);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_I);

  // 60-degree sector of the hue circle
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

  // Word handed from the front end to the back end
  typedef struct packed {
    sector_e            sector;
    logic [POS_W-1:0]   ramp;
    logic [CH_W-1:0]    chroma;
    logic [CH_W-1:0]    offset;
  } mid_t;

endpackage

`default_nettype wire

/* hw/rtl/hsv2rgb_if.sv */
// Valid/ready channel interfaces for the HSV input and RGB output words.
// Depends on hsv2rgb_pkg for field widths.
`default_nettype none

interface hsv2rgb_hsv_if
  import hsv2rgb_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_rgb_if
  import hsv2rgb_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hsv2rgb_to_rgb_converter_top.sv */
// Top level of the HSV to RGB converter: front end and back end pipelines.
// Depends on hsv2rgb_pkg, hsv2rgb_if, hsv2rgb_front and hsv2rgb_back.
`default_nettype none

//  channel | dir | word fields                       | handshake
//  --------+-----+-----------------------------------+-------------
//  hsv_i   | in  | hue[15:0] saturation[12:0]        | valid/ready
//          |     | brightness[12:0]                  |
//  rgb_o   | out | red[12:0] green[12:0] blue[12:0]  | valid/ready
//
// Five register stages; a word taken from hsv_i passes through them to rgb_o. One
// word per cycle sustained while rgb_o is not stalled: every stage takes a new word
// as it hands its current one on; ready ripples back through all stages at once.
// Reset clears only the stage valid bits; no clearing pass, no warm-up.
// A stall on rgb_o holds each full stage in place; empty stages still fill,
// so bubbles close up and no word is dropped or repeated.

module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  hsv2rgb_hsv_if.sink    hsv_i,
  hsv2rgb_rgb_if.source  rgb_o
);

  // Word between the two halves: sector, ramp numerator, chroma, offset
  logic mid_valid;
  logic mid_ready;
  mid_t mid;

  // Stages 1-2: wrap hue, clamp S and V, form chroma and the sector
  hsv2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hsv_i       (hsv_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  // Stages 3-5: ramp term, component order, offset, output register
  hsv2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .rgb_o       (rgb_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_front.sv */
// Front end, two stages: hue reduction, clamping, V*S, then chroma, sector, ramp.
// Depends on hsv2rgb_pkg and hsv2rgb_hsv_if.
`default_nettype none

module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  hsv2rgb_hsv_if.sink         hsv_i,
  output logic                mid_valid_o,
  input  logic                mid_ready_i,
  output mid_t                mid_o
);

  logic              s1_vld_q, s2_vld_q;
  logic              en1, en2;

  logic [H_W-1:0]    h_d, h_q;
  logic [CH_W-1:0]   v_d, v_q;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [HUE_W-1:0]  hue_sub;
  logic [CH_W-1:0]   s_cl;

  logic [PROD_W-1:0] prod_rnd;
  logic [2:0]        sec;
  logic [H_W-1:0]    base;
  logic [POS_W-1:0]  pos;
  mid_t              mid_d, mid_q;

  // Advance a stage when it is empty or its word moves on
  assign en2           = !s2_vld_q || mid_ready_i;
  assign en1           = !s1_vld_q || en2;
  assign hsv_i.ready   = en1;
  assign mid_valid_o   = s2_vld_q;
  assign mid_o         = mid_q;

  // Stage 1: wrap hue into one turn, clamp S and V, multiply
  always_comb begin
    if (hsv_i.hue >= TURN2) begin
      hue_sub = hsv_i.hue - TURN2;
    end else if (hsv_i.hue >= TURN) begin
      hue_sub = hsv_i.hue - TURN;
    end else begin
      hue_sub = hsv_i.hue;
    end
    h_d    = hue_sub[H_W-1:0];
    s_cl   = (hsv_i.saturation > ONE) ? ONE : hsv_i.saturation;
    v_d    = (hsv_i.brightness > ONE) ? ONE : hsv_i.brightness;
    prod_d = PROD_W'(v_d) * PROD_W'(s_cl);
  end

  // Stage 2: round chroma, find sector and ramp, form offset
  always_comb begin
    prod_rnd = prod_q + HALF_ONE;
    sec      = 3'd0;
    base     = '0;
    for (int k = 1; k < 6; k++) begin
      if (h_q >= H_W'(k * SEG_I)) begin
        sec  = 3'(k);
        base = H_W'(k * SEG_I);
      end
    end
    pos          = POS_W'(h_q - base);
    mid_d.sector = sector_e'(sec);
    mid_d.ramp   = sec[0] ? (SEG - pos) : pos;
    mid_d.chroma = prod_rnd[FRAC_BITS +: CH_W];
    mid_d.offset = v_q - mid_d.chroma;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q <= hsv_i.valid;
      if (en2) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      h_q    <= h_d;
      v_q    <= v_d;
      prod_q <= prod_d;
    end
    if (en2) begin
      mid_q <= mid_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_back.sv */
// Back end, three stages: C*ramp, divide by the sector width, order and offset.
// Depends on hsv2rgb_pkg and hsv2rgb_rgb_if.
`default_nettype none

module hsv2rgb_back
  import hsv2rgb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mid_valid_i,
  output logic                mid_ready_o,
  input  mid_t                mid_i,
  hsv2rgb_rgb_if.source       rgb_o
);

  logic             s3_vld_q, s4_vld_q, s5_vld_q;
  logic             en3, en4, en5;

  // stage 3
  logic [CR_W-1:0]  cr_d, cr_q;
  sector_e          sec3_q;
  logic [CH_W-1:0]  c3_q, m3_q;
  // stage 4
  logic [CR_W:0]    cr_rnd;
  logic [T_W-1:0]   t_w;
  logic [Q_W-1:0]   qp_d, qp_q;
  sector_e          sec4_q;
  logic [CH_W-1:0]  c4_q, m4_q;
  // stage 5
  logic [CH_W-1:0]  x_w;
  logic [CH_W-1:0]  r_d, g_d, b_d;
  logic [CH_W-1:0]  r_q, g_q, b_q;

  assign en5         = !s5_vld_q || rgb_o.ready;
  assign en4         = !s4_vld_q || en5;
  assign en3         = !s3_vld_q || en4;
  assign mid_ready_o = en3;

  assign rgb_o.valid = s5_vld_q;
  assign rgb_o.red   = r_q;
  assign rgb_o.green = g_q;
  assign rgb_o.blue  = b_q;

  // Stage 3: chroma times ramp numerator
  assign cr_d = CR_W'(CR_W'(mid_i.chroma) * CR_W'(mid_i.ramp));

  // Stage 4: round, drop the power-of-two part, multiply by the reciprocal
  always_comb begin
    cr_rnd = {1'b0, cr_q} + HALF_SEG;
    t_w    = cr_rnd[SEG_SHIFT +: T_W];
    qp_d   = Q_W'(t_w) * Q_W'(RECIP);
  end

  // Stage 5: pick the component order and add the offset
  always_comb begin
    x_w = qp_q[RECIP_SHIFT +: CH_W];
    case (sec4_q)
      SEC_R_Y: begin r_d = c4_q; g_d = x_w;  b_d = '0;   end
      SEC_Y_G: begin r_d = x_w;  g_d = c4_q; b_d = '0;   end
      SEC_G_C: begin r_d = '0;   g_d = c4_q; b_d = x_w;  end
      SEC_C_B: begin r_d = '0;   g_d = x_w;  b_d = c4_q; end
      SEC_B_M: begin r_d = x_w;  g_d = '0;   b_d = c4_q; end
      default: begin r_d = c4_q; g_d = '0;   b_d = x_w;  end
    endcase
    r_d = r_d + m4_q;
    g_d = g_d + m4_q;
    b_d = b_d + m4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (en3) s3_vld_q <= mid_valid_i;
      if (en4) s4_vld_q <= s3_vld_q;
      if (en5) s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      cr_q   <= cr_d;
      sec3_q <= mid_i.sector;
      c3_q   <= mid_i.chroma;
      m3_q   <= mid_i.offset;
    end
    if (en4) begin
      qp_q   <= qp_d;
      sec4_q <= sec3_q;
      c4_q   <= c3_q;
      m4_q   <= m3_q;
    end
    if (en5) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

`ifndef SYNTH
  // The ramp term never exceeds chroma
  a_ramp_le_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q |-> (x_w <= c4_q))
    else $error("ramp term above chroma");

  // No component can go above one
  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_vld_q |-> ((r_q <= ONE) && (g_q <= ONE) && (b_q <= ONE)))
    else $error("output component above one");

  // One component carries the full value V = C + M
  a_out_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_vld_q && en5) |=> ((r_q == $past(c4_q + m4_q)) || (g_q == $past(c4_q + m4_q))
                           || (b_q == $past(c4_q + m4_q))))
    else $error("no component equals brightness");

  // One component sits at the offset alone
  a_out_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_vld_q && en5) |=> ((r_q == $past(m4_q)) || (g_q == $past(m4_q))
                           || (b_q == $past(m4_q))))
    else $error("no component equals offset");
`endif

endmodule

`default_nettype wire
